// ===== rtl/fps_pkg.sv =====
// fps_pkg: shared types, constants and sizing functions for the fenwick prefix-sum tree
// no dependencies; compiled first

package fps_pkg;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 11;
    localparam int SIZE_DEF = 1024;

    // item kinds
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // top-level control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } t_state;

    // token that walks the level chain (node number travels beside it)
    typedef struct packed {
        logic              vld;
        logic              kind;
        logic [DATA_W-1:0] acc;
    } t_tok;

    // number of tree levels: floor(log2(size)) + 1
    function automatic int num_levels(input int size);
        return $clog2(size + 1);
    endfunction

    // nodes whose lowest set bit is 2^lvl, within 1..size
    function automatic int lvl_depth(input int size, input int lvl);
        return ((size - (1 << lvl)) >> (lvl + 1)) + 1;
    endfunction

    // address width for a store of depth d
    function automatic int addr_w(input int d);
        return (d > 1) ? $clog2(d) : 1;
    endfunction

endpackage

// ===== rtl/fps_in_if.sv =====
// fps_in_if: valid/ready channel carrying add and query items
// depends on fps_pkg

interface fps_in_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic        [fps_pkg::IDX_W-1:0]    index;
    logic signed [fps_pkg::DATA_W-1:0]   delta;

    modport source (output valid, output kind, output index, output delta, input ready);
    modport sink   (input valid, input kind, input index, input delta, output ready);
endinterface

// ===== rtl/fps_out_if.sv =====
// fps_out_if: valid/ready channel carrying prefix-sum results
// depends on fps_pkg

interface fps_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fps_pkg::DATA_W-1:0]   prefix_sum;

    modport source (output valid, output prefix_sum, input ready);
    modport sink   (input valid, input prefix_sum, output ready);
endinterface

// ===== rtl/fps_level_cell.sv =====
// fps_level_cell: one tree level (all nodes whose lowest set bit is 2^LEVEL) in a node memory
// depends on fps_pkg; instantiated once per level by fenwick_prefix_sum_tree

module fps_level_cell #(
    parameter int SIZE  = fps_pkg::SIZE_DEF,
    parameter int LEVEL = 0,
    parameter int CUR_W = 12,
    parameter int CLR_W = 9
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr_en,
    input  logic [CLR_W-1:0]         i_clr_addr,
    input  fps_pkg::t_tok            i_tok,
    input  logic [CUR_W-1:0]         i_cur,
    output fps_pkg::t_tok            o_tok,
    output logic [CUR_W-1:0]         o_cur
);
    import fps_pkg::*;

    localparam int DEPTH = lvl_depth(SIZE, LEVEL);
    localparam int AW    = addr_w(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];

    t_tok              r_tok;
    logic [CUR_W-1:0]  r_cur;
    logic [DATA_W-1:0] r_rdata;

    logic [CUR_W-1:0]  w_rd_shift;
    logic [CUR_W-1:0]  w_wr_shift;
    logic [AW-1:0]     w_rd_addr;
    logic [AW-1:0]     w_wr_addr;
    logic              w_hit;
    logic              w_upd;
    logic              w_clr_hit;
    logic [CUR_W-1:0]  w_step;

    // node address within this level: node number without its low LEVEL+1 bits
    assign w_rd_shift = i_cur >> (LEVEL + 1);
    assign w_wr_shift = r_cur >> (LEVEL + 1);
    assign w_rd_addr  = w_rd_shift[AW-1:0];
    assign w_wr_addr  = w_wr_shift[AW-1:0];
    assign w_step     = CUR_W'(1) << LEVEL;

    // node at this level is on the walk when its lowest set bit sits here and it exists
    assign w_hit     = r_tok.vld && r_cur[LEVEL] && (r_cur <= CUR_W'(SIZE));
    assign w_upd     = w_hit && (r_tok.kind == KIND_ADD);
    assign w_clr_hit = i_clr_en && ({1'b0, i_clr_addr} < (CLR_W + 1)'(DEPTH));

    // token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
        end
        r_tok.kind <= i_tok.kind;
        r_tok.acc  <= i_tok.acc;
        r_cur      <= i_cur;
    end

    // node memory read, registered
    always_ff @(posedge i_clk) begin
        if (i_tok.vld) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // node memory write: clearing pass or read-modify-write of an add
    always_ff @(posedge i_clk) begin
        if (w_clr_hit) begin
            mem[i_clr_addr[AW-1:0]] <= '0;
        end else if (w_upd) begin
            mem[w_wr_addr] <= r_rdata + r_tok.acc;
        end
    end

    // hand the token to the next level
    always_comb begin
        o_tok = r_tok;
        o_cur = r_cur;
        if (w_hit) begin
            if (r_tok.kind == KIND_QUERY) begin
                o_tok.acc = r_tok.acc + r_rdata;
                o_cur     = r_cur & ~w_step;
            end else begin
                o_cur     = r_cur + w_step;
            end
        end
    end

endmodule

// ===== rtl/fenwick_prefix_sum_tree.sv =====
// fenwick_prefix_sum_tree: binary indexed tree, one level cell per tree level in a chain
// LEVELS = floor(log2(SIZE)) + 1 tree levels (11 at 1024); each level cell registers the token
// and it visits one level memory per cycle; no new item is taken before it leaves the top level
// reset: synchronous, active low; then a clearing pass zeroes the node memories,
// with no transfer accepted until it ends
// depends on fps_pkg, fps_in_if, fps_out_if, fps_level_cell

module fenwick_prefix_sum_tree #(
    parameter int SIZE = fps_pkg::SIZE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fps_in_if.sink          i_req,
    fps_out_if.source       o_rsp
);
    import fps_pkg::*;

    localparam int LEVELS = num_levels(SIZE);
    localparam int CUR_W  = LEVELS + 1;
    localparam int CMP_W  = (CUR_W > IDX_W) ? CUR_W : IDX_W;
    localparam int D0     = lvl_depth(SIZE, 0);
    localparam int CLR_W  = addr_w(D0);

    t_state             r_state;
    t_state             n_state;
    logic [CLR_W-1:0]   r_clr_addr;
    logic               r_out_vld;
    logic [DATA_W-1:0]  r_out_sum;
    logic [DATA_W-1:0]  r_hold;

    t_tok               w_tok [0:LEVELS];
    logic [CUR_W-1:0]   w_cur [0:LEVELS];
    logic [LEVELS-1:0]  w_live;

    logic               w_accept;
    logic               w_clr_en;
    logic               w_clr_done;
    logic               w_emit;
    logic               w_emit_q;
    logic               w_slot_free;
    logic               w_ld_chain;
    logic               w_ld_hold;
    logic               w_ld_from_hold;
    logic [CMP_W-1:0]   w_idx_ext;
    logic [CUR_W-1:0]   w_pos;

    // clamp the index to SIZE
    assign w_idx_ext = CMP_W'(i_req.index);
    assign w_pos     = (w_idx_ext > CMP_W'(SIZE)) ? CUR_W'(SIZE) : CUR_W'(w_idx_ext);

    // token injected at the bottom level
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_tok[0].vld  = w_accept;
    assign w_tok[0].kind = i_req.kind;
    assign w_tok[0].acc  = (i_req.kind == KIND_QUERY) ? '0 : DATA_W'(i_req.delta);
    assign w_cur[0]      = w_pos;

    // chain of level cells
    for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
        fps_level_cell #(
            .SIZE  (SIZE),
            .LEVEL (k),
            .CUR_W (CUR_W),
            .CLR_W (CLR_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clr_en   (w_clr_en),
            .i_clr_addr (r_clr_addr),
            .i_tok      (w_tok[k]),
            .i_cur      (w_cur[k]),
            .o_tok      (w_tok[k+1]),
            .o_cur      (w_cur[k+1])
        );
        assign w_live[k] = w_tok[k+1].vld;
    end

    // result leaving the top level
    assign w_emit      = w_tok[LEVELS].vld;
    assign w_emit_q    = w_emit && (w_tok[LEVELS].kind == KIND_QUERY);
    assign w_slot_free = !r_out_vld || o_rsp.ready;
    assign w_clr_done  = (r_clr_addr == CLR_W'(D0 - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_emit) begin
                    if (w_emit_q && !w_slot_free) begin
                        n_state = ST_HOLD;
                    end else if (w_accept) begin
                        n_state = ST_BUSY;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_HOLD: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready    = 1'b0;
        w_clr_en       = 1'b0;
        w_ld_chain     = 1'b0;
        w_ld_hold      = 1'b0;
        w_ld_from_hold = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_clr_en = 1'b1;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_BUSY: begin
                i_req.ready = w_emit && (!w_emit_q || w_slot_free);
                w_ld_chain  = w_emit_q && w_slot_free;
                w_ld_hold   = w_emit_q && !w_slot_free;
            end
            ST_HOLD: begin
                w_ld_from_hold = w_slot_free;
            end
            default: begin
                w_clr_en = 1'b0;
            end
        endcase
    end

    // state and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clr_en) begin
                r_clr_addr <= r_clr_addr + CLR_W'(1);
            end
        end
    end

    // output register and hold stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_ld_chain || w_ld_from_hold) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_ld_chain) begin
            r_out_sum <= w_tok[LEVELS].acc;
        end else if (w_ld_from_hold) begin
            r_out_sum <= r_hold;
        end
        if (w_ld_hold) begin
            r_hold <= w_tok[LEVELS].acc;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.prefix_sum = r_out_sum;

`ifndef SYNTHESIS
    // at most one token walks the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_live))
        else $error("more than one token in the level chain");

    // a query has removed every set bit of its node number by the top level
    a_query_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_q |-> (w_cur[LEVELS] == '0))
        else $error("query left the chain with bits still set");

    // a token leaves the chain only while busy
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (r_state == ST_BUSY))
        else $error("token emitted outside busy state");

    // hold is entered only behind a full output register
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_out_vld)
        else $error("hold state with empty output register");
`endif

endmodule
